@@ src/fct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants for the flow connection tracker
// Protocol numbers, TCP flag masks, connection states and register indexes.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [7:0] FlagFin    = 8'h01;
  localparam logic [7:0] FlagSyn    = 8'h02;
  localparam logic [7:0] FlagRst    = 8'h04;
  localparam logic [7:0] FlagAck    = 8'h10;
  localparam logic [7:0] FlagSynAck = 8'h12;

  localparam logic [31:0] UdpLimitReset  = 32'd30000;
  localparam logic [31:0] IcmpLimitReset = 32'd5000;

  typedef enum logic [1:0] {
    ST_CLOSED      = 2'd0,
    ST_SYN_SENT    = 2'd1,
    ST_ESTABLISHED = 2'd2,
    ST_FIN_WAIT    = 2'd3
  } conn_state_e;

  typedef enum logic {
    REG_UDP_LIMIT  = 1'b0,
    REG_ICMP_LIMIT = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_RESULT
  } phase_e;

  // normalized flow key
  typedef struct packed {
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [7:0]  proto;
  } flow_key_t;

  // request traveling down the cell chain
  typedef struct packed {
    logic        active;
    logic        mode;
    flow_key_t   key;
    logic [7:0]  flags;
    logic [31:0] now;
    logic [31:0] limit;
    logic        limited;   // protocol has an idle limit
    logic        done;      // already claimed by an earlier cell
    logic        accepted;
    logic        found;
    logic [1:0]  state;
  } chain_req_t;

endpackage

@@ src/fct_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_cell: one flow table entry in the lookup chain
// Holds one flow, compares the passing request against it and updates the
// entry on a hit. Create requests are resolved in two passes: the first pass
// looks for a match, the second takes the first free slot.
// ----------------------------------------------------------------------------
module fct_cell
  import fct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_req_t req_i,
  input  logic       pass2_i,   // second create pass: claim free slot
  output chain_req_t req_o
);

  logic        valid_q, valid_d;
  flow_key_t   key_q, key_d;
  logic [1:0]  state_q, state_d;
  logic [31:0] seen_q, seen_d;
  chain_req_t  req_q, req_d;
  logic        active_q;

  logic        hit;
  logic [31:0] idle;
  logic [1:0]  ns;

  always_comb begin
    hit     = valid_q && (key_q == req_i.key);
    idle    = req_i.now - seen_q;
    valid_d = valid_q;
    key_d   = key_q;
    state_d = state_q;
    seen_d  = seen_q;
    req_d   = req_i;
    ns      = state_q;
    if (req_i.active && !req_i.done) begin
      if (!req_i.mode) begin
        // check
        if (hit) begin
          req_d.done = 1'b1;
          if (req_i.limited && idle > req_i.limit) begin
            valid_d = 1'b0;
          end else begin
            seen_d = req_i.now;
            if (req_i.key.proto == ProtoTcp) begin
              priority if ((req_i.flags & FlagFin) != 8'd0) ns = ST_FIN_WAIT;
              else if ((req_i.flags & FlagRst) != 8'd0) ns = ST_CLOSED;
              else if (state_q == ST_SYN_SENT &&
                       (req_i.flags & (FlagAck | FlagSynAck)) != 8'd0)
                ns = ST_ESTABLISHED;
            end
            state_d        = ns;
            req_d.accepted = 1'b1;
            req_d.found    = 1'b1;
            req_d.state    = ns;
          end
        end
      end else if ((!pass2_i && hit) || (pass2_i && !valid_q)) begin
        // create: overwrite match, or claim first free slot
        if (req_i.key.proto == ProtoTcp) begin
          ns = ((req_i.flags & FlagSyn) != 8'd0) ? ST_SYN_SENT : ST_ESTABLISHED;
        end else begin
          ns = ST_CLOSED;
        end
        valid_d        = 1'b1;
        key_d          = req_i.key;
        state_d        = ns;
        seen_d         = req_i.now;
        req_d.done     = 1'b1;
        req_d.accepted = 1'b1;
        req_d.state    = ns;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= req_d.active;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    state_q <= state_d;
    seen_q  <= seen_d;
    req_q   <= req_d;
  end

  // active bit comes from the reset register
  always_comb begin
    req_o        = req_q;
    req_o.active = active_q;
  end

endmodule

@@ src/flow_connection_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_connection_tracker: stateful connection tracking
// Direction-free flow lookup and update in a chain of table cells.
// ----------------------------------------------------------------------------
// Each request travels through a chain of FLOW_ENTRIES cells, one cell per
// cycle; a check passes the chain once, as does a create that finds its
// match, and a create that misses its match makes a second pass through the
// chain before its result. One request is in flight at a time;
// the result waits in an output register and the next request is taken as
// soon as the result is taken or in the same cycle.
// No clearing pass is needed after reset.
module flow_connection_tracker
  import fct_pkg::*;
#(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        mode_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [7:0]  ip_proto_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [31:0] now_ms_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        accepted_o,
  output logic        flow_found_o,
  output logic [1:0]  flow_conn_state_o,
  output logic        table_full_o
);

  logic [31:0] udp_limit_q, icmp_limit_q;
  phase_e      phase_q, phase_d;
  logic        pass2_q, pass2_d;
  chain_req_t  head_req;
  chain_req_t  chain [FLOW_ENTRIES+1];
  logic        take;
  logic        reenter;
  logic        cell_pass2;
  logic        out_valid_q, out_valid_d;
  logic        res_acc_q, res_found_q, res_full_q;
  logic [1:0]  res_state_q;
  logic        res_acc_d, res_found_d, res_full_d;
  logic [1:0]  res_state_d;
  flow_key_t   in_key;
  logic        swap;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udp_limit_q  <= UdpLimitReset;
      icmp_limit_q <= IcmpLimitReset;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_UDP_LIMIT:  udp_limit_q  <= cfg_data_i;
        REG_ICMP_LIMIT: icmp_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key normalization
  always_comb begin
    swap = !(source_addr_i < dest_addr_i ||
             (source_addr_i == dest_addr_i && source_port_i < dest_port_i));
    in_key.addr_low  = swap ? dest_addr_i : source_addr_i;
    in_key.addr_high = swap ? source_addr_i : dest_addr_i;
    in_key.port_low  = swap ? dest_port_i : source_port_i;
    in_key.port_high = swap ? source_port_i : dest_port_i;
    in_key.proto     = ip_proto_i;
  end

  assign stall_o = (phase_q != PH_IDLE) && !(phase_q == PH_RESULT && !stall_i);
  assign take    = valid_i && !stall_o;

  // unmatched create leaving the chain after its first pass
  assign reenter = (phase_q == PH_SCAN) && chain[FLOW_ENTRIES].active &&
                   chain[FLOW_ENTRIES].mode && !chain[FLOW_ENTRIES].done &&
                   !pass2_q;

  // the first cell already sees the second pass in the re-entry cycle
  assign cell_pass2 = pass2_q || reenter;

  // chain head: new request, or the same request again for the second pass
  always_comb begin
    head_req = '0;
    if (take) begin
      head_req.active  = 1'b1;
      head_req.mode    = mode_i;
      head_req.key     = in_key;
      head_req.flags   = tcp_flag_bits_i;
      head_req.now     = now_ms_i;
      head_req.limited = (ip_proto_i == ProtoUdp) || (ip_proto_i == ProtoIcmp);
      head_req.limit   = (ip_proto_i == ProtoUdp) ? udp_limit_q : icmp_limit_q;
    end else if (reenter) begin
      head_req = chain[FLOW_ENTRIES];
    end
  end

  assign chain[0] = head_req;

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
    fct_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (chain[g]),
      .pass2_i(cell_pass2),
      .req_o  (chain[g+1])
    );
  end

  // sequencing and result register
  always_comb begin
    phase_d     = phase_q;
    pass2_d     = pass2_q;
    out_valid_d = out_valid_q;
    res_acc_d   = res_acc_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_state_d = res_state_q;
    if (out_valid_q && !stall_i) out_valid_d = 1'b0;
    if (phase_q == PH_RESULT && !stall_i) phase_d = PH_IDLE;
    if (phase_q == PH_SCAN && chain[FLOW_ENTRIES].active) begin
      if (reenter) begin
        pass2_d = 1'b1;
      end else begin
        phase_d     = PH_RESULT;
        pass2_d     = 1'b0;
        out_valid_d = 1'b1;
        res_acc_d   = chain[FLOW_ENTRIES].accepted;
        res_found_d = chain[FLOW_ENTRIES].found;
        res_state_d = chain[FLOW_ENTRIES].state;
        res_full_d  = chain[FLOW_ENTRIES].mode && !chain[FLOW_ENTRIES].done;
      end
    end
    if (take) begin
      phase_d = PH_SCAN;
      pass2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pass2_q     <= pass2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_state_q <= res_state_d;
  end

  assign valid_o           = out_valid_q;
  assign accepted_o        = res_acc_q;
  assign flow_found_o      = res_found_q;
  assign flow_conn_state_o = res_state_q;
  assign table_full_o      = res_full_q;

  // a full table never reports acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(table_full_o && accepted_o))
    else $error("full and accepted together");

  // the sequencer is in a known phase (idle, scan or result) while a result is raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> phase_q == PH_RESULT || phase_q == PH_SCAN || phase_q == PH_IDLE)
    else $error("result outside sequence");

  // no request is taken while a scan is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SCAN) |-> stall_o)
    else $error("request taken mid scan");

  // found is only reported with acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && flow_found_o |-> accepted_o)
    else $error("found without accept");

endmodule
